// ===== design/hsvpr_pkg.sv =====
// Package for the HSV fixture pixel renderer.
// Holds the transaction types, channel indexes and fixed-point constants.
// Has no dependencies; every design file takes its names from here.
package hsvpr_pkg;

  localparam int BYTE_W = 8;
  localparam int HUE_W = 11;
  localparam int ADDR_W = 10;
  localparam int OFFSET_W = 2;
  localparam int WEIGHT_W = 9;
  localparam int VM_W = 16;
  localparam int VEFF_W = 24;
  localparam int K_W = 16;
  localparam int LEVEL_W = 40;
  localparam int REM_W = 32;
  localparam int RECIP_W = 9;

  localparam int UNIVERSE_CHANNELS = 512;
  localparam int NUM_CHANNELS = 3;
  localparam int CH_RED = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE = 2;

  localparam logic [HUE_W-1:0] HUE_CIRCLE = 11'd1536;
  localparam logic [WEIGHT_W-1:0] SECTOR_SPAN = 9'd256;
  localparam logic [BYTE_W-1:0] MASTER_RESET = 8'd255;
  localparam logic [K_W-1:0] FULL_K = 16'd65280;
  localparam logic [REM_W-1:0] CUBE = 32'd16581375;
  localparam logic [LEVEL_W-1:0] HALF_DENOM = 40'd2122416000;
  localparam logic [RECIP_W-1:0] RECIP = 9'd259;

  localparam logic [2:0] SECTOR_RED_YELLOW = 3'd0;
  localparam logic [2:0] SECTOR_YELLOW_GREEN = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_CYAN = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLUE = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_MAGENTA = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STAGES = 3;
  localparam int PRE_STAGES = 4;
  localparam int BACK_STAGES = PRE_STAGES + DIV_STAGES;
  localparam int ACCEPT_TO_RESULT = 2 + BACK_STAGES;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [BYTE_W-1:0] saturation;
    logic [BYTE_W-1:0] brightness_value;
    logic [BYTE_W-1:0] fixture_gain;
    logic [ADDR_W-1:0] start_address;
    logic [OFFSET_W-1:0] offset_red;
    logic [OFFSET_W-1:0] offset_green;
    logic [OFFSET_W-1:0] offset_blue;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] blue_byte;
    logic [ADDR_W-1:0] red_address;
    logic [ADDR_W-1:0] green_address;
    logic [ADDR_W-1:0] blue_address;
    logic past_universe;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] red_address;
    logic [ADDR_W-1:0] green_address;
    logic [ADDR_W-1:0] blue_address;
    logic past_universe;
  } meta_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0][WEIGHT_W-1:0] weight;
    logic [BYTE_W-1:0] saturation;
    logic [VM_W-1:0] value_master;
    logic [BYTE_W-1:0] fixture_gain;
    meta_t meta;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/hsvpr_front.sv =====
// Front stage of the HSV fixture pixel renderer.
// Classifies the hue into a sector, builds channel weights and DMX addresses.
// Depends on hsvpr_pkg.
module hsvpr_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsvpr_pkg::pixel_t pixel,
  input  logic [hsvpr_pkg::BYTE_W-1:0] master,
  input  hsvpr_pkg::queue_status_t status,
  output logic push,
  output hsvpr_pkg::job_t job
);

  logic job_valid;
  logic accept;
  logic [hsvpr_pkg::HUE_W-1:0] hue_wrapped;
  logic [2:0] sector;
  logic [hsvpr_pkg::BYTE_W-1:0] pos;
  logic [hsvpr_pkg::WEIGHT_W-1:0] ramp;
  logic [hsvpr_pkg::NUM_CHANNELS-1:0][hsvpr_pkg::WEIGHT_W-1:0] weight;
  logic [hsvpr_pkg::ADDR_W:0] sum_red;
  logic [hsvpr_pkg::ADDR_W:0] sum_green;
  logic [hsvpr_pkg::ADDR_W:0] sum_blue;
  logic [hsvpr_pkg::ADDR_W:0] limit;
  hsvpr_pkg::job_t job_next;

  assign push = job_valid && !status.full;
  assign busy = job_valid && status.full;
  assign accept = start && !busy;
  assign limit = (hsvpr_pkg::ADDR_W + 1)'(hsvpr_pkg::UNIVERSE_CHANNELS);

  always_comb begin
    hue_wrapped = (pixel.hue >= hsvpr_pkg::HUE_CIRCLE) ?
                  pixel.hue - hsvpr_pkg::HUE_CIRCLE : pixel.hue;
    sector = hue_wrapped[hsvpr_pkg::HUE_W-1:hsvpr_pkg::BYTE_W];
    pos = hue_wrapped[hsvpr_pkg::BYTE_W-1:0];
    ramp = sector[0] ? (hsvpr_pkg::SECTOR_SPAN - {1'b0, pos}) : {1'b0, pos};
    case (sector)
      hsvpr_pkg::SECTOR_RED_YELLOW: begin
        weight[hsvpr_pkg::CH_RED] = hsvpr_pkg::SECTOR_SPAN;
        weight[hsvpr_pkg::CH_GREEN] = ramp;
        weight[hsvpr_pkg::CH_BLUE] = '0;
      end
      hsvpr_pkg::SECTOR_YELLOW_GREEN: begin
        weight[hsvpr_pkg::CH_RED] = ramp;
        weight[hsvpr_pkg::CH_GREEN] = hsvpr_pkg::SECTOR_SPAN;
        weight[hsvpr_pkg::CH_BLUE] = '0;
      end
      hsvpr_pkg::SECTOR_GREEN_CYAN: begin
        weight[hsvpr_pkg::CH_RED] = '0;
        weight[hsvpr_pkg::CH_GREEN] = hsvpr_pkg::SECTOR_SPAN;
        weight[hsvpr_pkg::CH_BLUE] = ramp;
      end
      hsvpr_pkg::SECTOR_CYAN_BLUE: begin
        weight[hsvpr_pkg::CH_RED] = '0;
        weight[hsvpr_pkg::CH_GREEN] = ramp;
        weight[hsvpr_pkg::CH_BLUE] = hsvpr_pkg::SECTOR_SPAN;
      end
      hsvpr_pkg::SECTOR_BLUE_MAGENTA: begin
        weight[hsvpr_pkg::CH_RED] = ramp;
        weight[hsvpr_pkg::CH_GREEN] = '0;
        weight[hsvpr_pkg::CH_BLUE] = hsvpr_pkg::SECTOR_SPAN;
      end
      default: begin
        weight[hsvpr_pkg::CH_RED] = hsvpr_pkg::SECTOR_SPAN;
        weight[hsvpr_pkg::CH_GREEN] = '0;
        weight[hsvpr_pkg::CH_BLUE] = ramp;
      end
    endcase

    sum_red = {1'b0, pixel.start_address} +
              {{(hsvpr_pkg::ADDR_W + 1 - hsvpr_pkg::OFFSET_W){1'b0}}, pixel.offset_red};
    sum_green = {1'b0, pixel.start_address} +
                {{(hsvpr_pkg::ADDR_W + 1 - hsvpr_pkg::OFFSET_W){1'b0}}, pixel.offset_green};
    sum_blue = {1'b0, pixel.start_address} +
               {{(hsvpr_pkg::ADDR_W + 1 - hsvpr_pkg::OFFSET_W){1'b0}}, pixel.offset_blue};

    job_next.weight = weight;
    job_next.saturation = pixel.saturation;
    job_next.value_master = hsvpr_pkg::VM_W'(pixel.brightness_value) *
                            hsvpr_pkg::VM_W'(master);
    job_next.fixture_gain = pixel.fixture_gain;
    job_next.meta.red_address = sum_red[hsvpr_pkg::ADDR_W-1:0];
    job_next.meta.green_address = sum_green[hsvpr_pkg::ADDR_W-1:0];
    job_next.meta.blue_address = sum_blue[hsvpr_pkg::ADDR_W-1:0];
    job_next.meta.past_universe = (sum_red > limit) || (sum_green > limit) ||
                                  (sum_blue > limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (push) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

// ===== design/hsvpr_queue.sv =====
// Short job queue between the front and back stages of the pixel renderer.
// Flip-flop entries with read and write pointers. Depends on hsvpr_pkg.
module hsvpr_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  hsvpr_pkg::job_t wr_job,
  input  logic pop,
  output hsvpr_pkg::job_t rd_job,
  output hsvpr_pkg::queue_status_t status
);

  hsvpr_pkg::job_t entries [hsvpr_pkg::QUEUE_DEPTH];
  logic [hsvpr_pkg::QPTR_W-1:0] wptr;
  logic [hsvpr_pkg::QPTR_W-1:0] rptr;
  logic [hsvpr_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full = (count == hsvpr_pkg::QCNT_W'(hsvpr_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign rd_job = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == hsvpr_pkg::QPTR_W'(hsvpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == hsvpr_pkg::QPTR_W'(hsvpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wr_job;
    end
  end

endmodule

// ===== design/hsvpr_back.sv =====
// Back pipeline of the HSV fixture pixel renderer.
// Scales, multiplies and rounds each channel level to a byte, dividing by a
// constant with a reciprocal multiply and one correction step. Depends on hsvpr_pkg.
module hsvpr_back (
  input  logic clk,
  input  logic rst,
  input  hsvpr_pkg::queue_status_t status,
  input  hsvpr_pkg::job_t rd_job,
  output logic pop,
  output logic result_valid,
  output hsvpr_pkg::result_t result
);

  logic [hsvpr_pkg::BACK_STAGES-1:0] vld;
  hsvpr_pkg::meta_t meta [hsvpr_pkg::BACK_STAGES];

  logic [hsvpr_pkg::VEFF_W-1:0] veff1;
  logic [hsvpr_pkg::VEFF_W-1:0] veff2;
  logic [hsvpr_pkg::K_W-1:0] sw1 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::K_W-1:0] k2 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::LEVEL_W-1:0] l3 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::REM_W-1:0] m4 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::REM_W-1:0] m5 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::BYTE_W-1:0] qest5 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::REM_W-1:0] m6 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::REM_W-1:0] prod6 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::BYTE_W-1:0] qest6 [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::BYTE_W-1:0] q7 [hsvpr_pkg::NUM_CHANNELS];

  logic [hsvpr_pkg::K_W:0] sw_prod [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::LEVEL_W-1:0] m_sum [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::REM_W+hsvpr_pkg::BYTE_W-1:0] recip_prod [hsvpr_pkg::NUM_CHANNELS];
  logic [hsvpr_pkg::REM_W-1:0] diff6 [hsvpr_pkg::NUM_CHANNELS];

  assign pop = !status.empty;

  always_comb begin
    for (int ch = 0; ch < hsvpr_pkg::NUM_CHANNELS; ch++) begin
      sw_prod[ch] = (hsvpr_pkg::K_W + 1)'(rd_job.saturation) *
                    (hsvpr_pkg::K_W + 1)'(hsvpr_pkg::SECTOR_SPAN - rd_job.weight[ch]);
      m_sum[ch] = l3[ch] + hsvpr_pkg::HALF_DENOM;
      recip_prod[ch] = (hsvpr_pkg::REM_W + hsvpr_pkg::BYTE_W)'(m4[ch]) *
                       (hsvpr_pkg::REM_W + hsvpr_pkg::BYTE_W)'(hsvpr_pkg::RECIP);
      diff6[ch] = m6[ch] - prod6[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[hsvpr_pkg::BACK_STAGES-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    meta[0] <= rd_job.meta;
    for (int s = 1; s < hsvpr_pkg::BACK_STAGES; s++) begin
      meta[s] <= meta[s-1];
    end
    veff1 <= hsvpr_pkg::VEFF_W'(rd_job.value_master) * hsvpr_pkg::VEFF_W'(rd_job.fixture_gain);
    veff2 <= veff1;
    for (int ch = 0; ch < hsvpr_pkg::NUM_CHANNELS; ch++) begin
      sw1[ch] <= sw_prod[ch][hsvpr_pkg::K_W-1:0];
      k2[ch] <= hsvpr_pkg::FULL_K - sw1[ch];
      l3[ch] <= hsvpr_pkg::LEVEL_W'(veff2) * hsvpr_pkg::LEVEL_W'(k2[ch]);
      m4[ch] <= m_sum[ch][hsvpr_pkg::LEVEL_W-1:hsvpr_pkg::LEVEL_W-hsvpr_pkg::REM_W];
      m5[ch] <= m4[ch];
      qest5[ch] <= recip_prod[ch][hsvpr_pkg::REM_W+hsvpr_pkg::BYTE_W-1:hsvpr_pkg::REM_W];
      m6[ch] <= m5[ch];
      qest6[ch] <= qest5[ch];
      prod6[ch] <= hsvpr_pkg::REM_W'(qest5[ch]) * hsvpr_pkg::CUBE;
      q7[ch] <= (diff6[ch] >= hsvpr_pkg::CUBE) ? qest6[ch] + 1'b1 : qest6[ch];
    end
  end

  assign result_valid = vld[hsvpr_pkg::BACK_STAGES-1];
  assign result.red_byte = q7[hsvpr_pkg::CH_RED];
  assign result.green_byte = q7[hsvpr_pkg::CH_GREEN];
  assign result.blue_byte = q7[hsvpr_pkg::CH_BLUE];
  assign result.red_address = meta[hsvpr_pkg::BACK_STAGES-1].red_address;
  assign result.green_address = meta[hsvpr_pkg::BACK_STAGES-1].green_address;
  assign result.blue_address = meta[hsvpr_pkg::BACK_STAGES-1].blue_address;
  assign result.past_universe = meta[hsvpr_pkg::BACK_STAGES-1].past_universe;

endmodule

// ===== design/hsv_fixture_pixel_render_core.sv =====
// Top level of the HSV fixture pixel renderer.
// Instantiates hsvpr_front, hsvpr_queue and hsvpr_back; depends on hsvpr_pkg.
//
// Usage: a pixel transaction is taken on a rising edge where start is high and
// busy is low; pixel carries hue, saturation, value, fixture gain, the DMX
// start channel and the three channel offsets. Each transaction yields one
// result, shown on result for a single cycle while result_valid is high. The
// receiver cannot stall, so results must be taken as they appear.
// The master brightness register is written through cfg_valid, cfg_ready and
// cfg_data; cfg_ready is always high, and writes belong in idle periods.
// One pixel is accepted every cycle while busy is low. An accepted pixel passes
// through the front register, the two-entry job queue, four multiply and
// rounding stages and a three-stage divide by a constant: a reciprocal
// multiply, a product of the estimate and one correction step.
// Reset clears the pipeline, empties the queue and sets master brightness to
// full scale; busy stays low in normal operation because the back pipeline
// drains the queue every cycle.
module hsv_fixture_pixel_render_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsvpr_pkg::pixel_t pixel,
  output logic result_valid,
  output hsvpr_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [hsvpr_pkg::BYTE_W-1:0] cfg_data
);

  logic [hsvpr_pkg::BYTE_W-1:0] master;
  logic push;
  logic pop;
  logic accept;
  hsvpr_pkg::job_t wr_job;
  hsvpr_pkg::job_t rd_job;
  hsvpr_pkg::queue_status_t status;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      master <= hsvpr_pkg::MASTER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      master <= cfg_data;
    end
  end

  hsvpr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .master (master),
    .status (status),
    .push   (push),
    .job    (wr_job)
  );

  hsvpr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .status (status)
  );

  hsvpr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .status       (status),
    .rd_job       (rd_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("Queue filled although the back pipeline drains it every cycle.");

  a_accept_yields_result: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(hsvpr_pkg::ACCEPT_TO_RESULT) result_valid)
    else $error("Accepted transaction did not produce a result on time.");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, hsvpr_pkg::ACCEPT_TO_RESULT))
    else $error("Result appeared without a matching accepted transaction.");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hsv_fixture_pixel_render_core.
// It drives pixel and master brightness transactions and predicts each result in a scoreboard.
// It depends on hsvpr_pkg and the core RTL only.
module tb;

  localparam longint unsigned LEVEL_DENOM = 64'd4244832000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 122;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  hsvpr_pkg::pixel_t pixel = '0;
  logic result_valid;
  hsvpr_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hsvpr_pkg::BYTE_W-1:0] cfg_data = '0;

  class pixel_scoreboard;
    hsvpr_pkg::result_t pending_colors[$];
    logic [hsvpr_pkg::BYTE_W-1:0] master;
    int errors;

    function new();
      master = hsvpr_pkg::MASTER_RESET;
      errors = 0;
    endfunction

    function void set_master(logic [hsvpr_pkg::BYTE_W-1:0] level);
      master = level;
    endfunction

    function int unsigned outstanding();
      return pending_colors.size();
    endfunction

    function logic [hsvpr_pkg::BYTE_W-1:0] level_byte(longint unsigned v_eff,
                                                      int unsigned sat, int unsigned w);
      longint unsigned k;
      longint unsigned q;
      k = 64'(hsvpr_pkg::FULL_K) - 64'(sat) * (64'(hsvpr_pkg::SECTOR_SPAN) - 64'(w));
      q = (v_eff * k + LEVEL_DENOM / 2) / LEVEL_DENOM;
      return (q > 255) ? 8'd255 : q[hsvpr_pkg::BYTE_W-1:0];
    endfunction

    function hsvpr_pkg::result_t render_pixel(hsvpr_pkg::pixel_t p);
      hsvpr_pkg::result_t r;
      logic [hsvpr_pkg::HUE_W-1:0] h;
      logic [2:0] sector;
      int unsigned pos, ramp, wr, wg, wb, ar, ag, ab;
      longint unsigned v_eff;
      h = p.hue;
      if (h >= hsvpr_pkg::HUE_CIRCLE) h = h - hsvpr_pkg::HUE_CIRCLE;
      sector = h[hsvpr_pkg::HUE_W-1:8];
      pos = 32'(h[7:0]);
      ramp = sector[0] ? 32'(hsvpr_pkg::SECTOR_SPAN) - pos : pos;
      case (sector)
        hsvpr_pkg::SECTOR_RED_YELLOW: begin
          wr = 32'(hsvpr_pkg::SECTOR_SPAN); wg = ramp; wb = 0;
        end
        hsvpr_pkg::SECTOR_YELLOW_GREEN: begin
          wr = ramp; wg = 32'(hsvpr_pkg::SECTOR_SPAN); wb = 0;
        end
        hsvpr_pkg::SECTOR_GREEN_CYAN: begin
          wr = 0; wg = 32'(hsvpr_pkg::SECTOR_SPAN); wb = ramp;
        end
        hsvpr_pkg::SECTOR_CYAN_BLUE: begin
          wr = 0; wg = ramp; wb = 32'(hsvpr_pkg::SECTOR_SPAN);
        end
        hsvpr_pkg::SECTOR_BLUE_MAGENTA: begin
          wr = ramp; wg = 0; wb = 32'(hsvpr_pkg::SECTOR_SPAN);
        end
        default: begin
          wr = 32'(hsvpr_pkg::SECTOR_SPAN); wg = 0; wb = ramp;
        end
      endcase
      v_eff = 64'(p.brightness_value);
      v_eff = v_eff * 64'(master) * 64'(p.fixture_gain);
      ar = 32'(p.start_address) + 32'(p.offset_red);
      ag = 32'(p.start_address) + 32'(p.offset_green);
      ab = 32'(p.start_address) + 32'(p.offset_blue);
      r.red_byte = level_byte(v_eff, 32'(p.saturation), wr);
      r.green_byte = level_byte(v_eff, 32'(p.saturation), wg);
      r.blue_byte = level_byte(v_eff, 32'(p.saturation), wb);
      r.red_address = ar[hsvpr_pkg::ADDR_W-1:0];
      r.green_address = ag[hsvpr_pkg::ADDR_W-1:0];
      r.blue_address = ab[hsvpr_pkg::ADDR_W-1:0];
      r.past_universe = (ar > hsvpr_pkg::UNIVERSE_CHANNELS) ||
                        (ag > hsvpr_pkg::UNIVERSE_CHANNELS) ||
                        (ab > hsvpr_pkg::UNIVERSE_CHANNELS);
      return r;
    endfunction

    function void note_pixel(hsvpr_pkg::pixel_t p);
      pending_colors = {pending_colors, render_pixel(p)};
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      end
    endfunction

    function void check_result(hsvpr_pkg::result_t got);
      hsvpr_pkg::result_t exp_color;
      if (pending_colors.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result %h arrived with no pixel pending", $time, got);
        return;
      end
      exp_color = pending_colors.pop_front();
      compare_field("red_byte", 32'(exp_color.red_byte), 32'(got.red_byte));
      compare_field("green_byte", 32'(exp_color.green_byte), 32'(got.green_byte));
      compare_field("blue_byte", 32'(exp_color.blue_byte), 32'(got.blue_byte));
      compare_field("red_address", 32'(exp_color.red_address), 32'(got.red_address));
      compare_field("green_address", 32'(exp_color.green_address), 32'(got.green_address));
      compare_field("blue_address", 32'(exp_color.blue_address), 32'(got.blue_address));
      compare_field("past_universe", 32'(exp_color.past_universe), 32'(got.past_universe));
    endfunction
  endclass

  pixel_scoreboard colors = new();
  bit burst_mode;

  hsv_fixture_pixel_render_core i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pixel(pixel),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) colors.note_pixel(pixel);
      if (cfg_valid && cfg_ready) colors.set_master(cfg_data);
      if (result_valid) colors.check_result(result);
    end
  end

  function automatic hsvpr_pkg::pixel_t make_pixel(int unsigned hue, int unsigned sat,
                                                   int unsigned val, int unsigned gain,
                                                   int unsigned addr, int unsigned off_r,
                                                   int unsigned off_g, int unsigned off_b);
    hsvpr_pkg::pixel_t p;
    p.hue = hsvpr_pkg::HUE_W'(hue);
    p.saturation = hsvpr_pkg::BYTE_W'(sat);
    p.brightness_value = hsvpr_pkg::BYTE_W'(val);
    p.fixture_gain = hsvpr_pkg::BYTE_W'(gain);
    p.start_address = hsvpr_pkg::ADDR_W'(addr);
    p.offset_red = hsvpr_pkg::OFFSET_W'(off_r);
    p.offset_green = hsvpr_pkg::OFFSET_W'(off_g);
    p.offset_blue = hsvpr_pkg::OFFSET_W'(off_b);
    return p;
  endfunction

  function automatic int unsigned pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic hsvpr_pkg::pixel_t random_pixel();
    int unsigned hue, addr, r;
    hue = ($urandom_range(0, 4) == 0) ? $urandom_range(1536, 2047) : $urandom_range(0, 1535);
    r = $urandom_range(0, 99);
    if (r < 65) addr = $urandom_range(1, 512);
    else if (r < 80) addr = $urandom_range(505, 512);
    else addr = $urandom_range(0, 1023);
    return make_pixel(hue, pick_byte(), pick_byte(), pick_byte(), addr,
                      $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(hsvpr_pkg::pixel_t p, int unsigned gap);
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (colors.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_master(logic [hsvpr_pkg::BYTE_W-1:0] level);
    cfg_valid <= 1'b1;
    cfg_data <= level;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_directed();
    send_pixel(make_pixel(0, 0, 0, 0, 1, 0, 1, 2), 0);
    send_pixel(make_pixel(0, 255, 255, 255, 1, 0, 1, 2), 0);
    send_pixel(make_pixel(255, 255, 255, 255, 100, 2, 1, 0), 0);
    send_pixel(make_pixel(256, 255, 255, 255, 200, 0, 1, 2), 0);
    send_pixel(make_pixel(511, 200, 255, 255, 7, 1, 2, 0), 0);
    send_pixel(make_pixel(512, 255, 128, 255, 9, 0, 0, 0), 0);
    send_pixel(make_pixel(767, 128, 255, 200, 33, 2, 2, 2), 0);
    send_pixel(make_pixel(768, 255, 255, 255, 64, 0, 1, 2), 0);
    send_pixel(make_pixel(1023, 64, 255, 255, 128, 1, 0, 2), 0);
    send_pixel(make_pixel(1024, 255, 255, 255, 256, 2, 0, 1), 0);
    send_pixel(make_pixel(1279, 255, 100, 255, 300, 0, 2, 1), 0);
    send_pixel(make_pixel(1280, 255, 255, 255, 400, 1, 1, 1), 0);
    send_pixel(make_pixel(1535, 255, 255, 255, 500, 0, 1, 2), 0);
    send_pixel(make_pixel(1536, 255, 255, 255, 2, 0, 1, 2), 0);
    send_pixel(make_pixel(2047, 128, 200, 77, 3, 2, 1, 0), 0);
    send_pixel(make_pixel(700, 255, 255, 1, 511, 0, 1, 2), 0);
    send_pixel(make_pixel(900, 1, 1, 255, 510, 0, 1, 2), 0);
    send_pixel(make_pixel(1100, 255, 255, 255, 512, 3, 3, 3), 0);
    send_pixel(make_pixel(1300, 0, 255, 255, 0, 0, 0, 0), 0);
    send_pixel(make_pixel(1400, 255, 1, 1, 1023, 3, 2, 1), 0);
    send_pixel(make_pixel(11'h555, 8'h55, 8'hAA, 8'h55, 10'h155, 1, 2, 3), 0);
    send_pixel(make_pixel(11'h2AA, 8'hAA, 8'h55, 8'hAA, 10'h2AA, 2, 1, 3), 0);
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_pixel(random_pixel(), pick_gap());
    end
  endtask

  initial begin
    logic [hsvpr_pkg::BYTE_W-1:0] settings[5];
    settings[0] = 8'd0;
    settings[1] = 8'd1;
    settings[2] = 8'd128;
    settings[3] = 8'($urandom_range(2, 254));
    settings[4] = 8'd255;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    send_random(RANDOM_PER_PHASE);
    for (int i = 0; i < 5; i++) begin
      wait_idle();
      write_master(settings[i]);
      send_random(RANDOM_PER_PHASE);
    end
    wait_idle();
    if (colors.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
